// ----- hw/rtl/ptw_pkg.sv -----
// shared types, codes and the microcode program of the page walker
package ptw_pkg;

	// default size of the table memory in 32-bit words
	localparam int unsigned MEM_WORDS_DEF = 16384;

	// a byte address without its two low bits
	localparam int WORD_W = 30;

	// item function codes
	localparam logic [1:0] FUNC_XLATE = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// configuration register indexes
	localparam logic CFG_PDB    = 1'b0;
	localparam logic CFG_PAGING = 1'b1;

	// page table entry bit positions
	localparam int ENT_P  = 0;
	localparam int ENT_RW = 1;
	localparam int ENT_A  = 5;
	localparam int ENT_D  = 6;
	localparam int ENT_PS = 7;

	localparam int STEP_W = 5;

	// microprogram steps; fall-through follows this order
	typedef enum logic [STEP_W-1:0] {
		ST_FETCH,
		ST_DISP,
		ST_PGCHK,
		ST_RDDIR,
		ST_LDPDE,
		ST_PSCHK,
		ST_BIGRW,
		ST_BIGWB,
		ST_RDTBL,
		ST_LDPTE,
		ST_PTERW,
		ST_WBPDE,
		ST_WBPTE,
		ST_FAULT,
		ST_PASS,
		ST_MEMDISP,
		ST_RDMEM,
		ST_RDLD,
		ST_RDOOR,
		ST_WRCHK,
		ST_WRMEM,
		ST_ZERO,
		ST_DONE
	} step_t;

	typedef enum logic [1:0] {
		AS_DIR,
		AS_TBL,
		AS_ITEM
	} addr_sel_t;

	typedef enum logic [1:0] {
		WS_ITEM,
		WS_PDE_ACC,
		WS_PDE_BIG,
		WS_PTE
	} wdata_sel_t;

	typedef enum logic [2:0] {
		RS_NONE,
		RS_VA,
		RS_BIG,
		RS_SMALL,
		RS_RDATA,
		RS_ONES,
		RS_ZERO
	} res_sel_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_IN_BEAT,
		C_OUT_FREE,
		C_FUNC_MEM,
		C_PAGING_OFF,
		C_DIR_OOR,
		C_RD_ABSENT,
		C_PDE_SMALL,
		C_PDE_DENY,
		C_TBL_OOR,
		C_PTE_DENY,
		C_NOT_READ,
		C_ITEM_OOR,
		C_NO_WRITE
	} cond_t;

	// datapath controls of one step
	typedef struct packed {
		logic       in_take;
		logic       mem_rd;
		logic       mem_we;
		addr_sel_t  addr_sel;
		wdata_sel_t wdata_sel;
		logic       ld_pde;
		logic       ld_pte;
		res_sel_t   res_sel;
		logic       set_fault;
		logic       out_load;
	} ctl_t;

	// datapath flags the sequencer branches on
	typedef struct packed {
		logic in_beat;
		logic out_free;
		logic func_mem;
		logic paging_off;
		logic dir_oor;
		logic rd_absent;
		logic pde_small;
		logic pde_deny;
		logic tbl_oor;
		logic pte_deny;
		logic not_read;
		logic item_oor;
		logic no_write;
	} stat_t;

	// one control word
	typedef struct packed {
		ctl_t  ctl;
		cond_t cond;
		step_t target;
		logic  nt_hold;
	} uc_t;

	// microprogram rom
	function automatic uc_t ucode_rom(input step_t st);
		uc_t w;
		w = '0;
		w.ctl.addr_sel  = AS_DIR;
		w.ctl.wdata_sel = WS_ITEM;
		w.ctl.res_sel   = RS_NONE;
		w.cond          = C_NEVER;
		w.target        = ST_FETCH;
		case (st)
			ST_FETCH: begin
				w.ctl.in_take = 1'b1;
				w.cond        = C_IN_BEAT;
				w.target      = ST_DISP;
				w.nt_hold     = 1'b1;
			end
			ST_DISP: begin
				w.cond   = C_FUNC_MEM;
				w.target = ST_MEMDISP;
			end
			ST_PGCHK: begin
				w.cond   = C_PAGING_OFF;
				w.target = ST_PASS;
			end
			ST_RDDIR: begin
				w.ctl.mem_rd   = 1'b1;
				w.ctl.addr_sel = AS_DIR;
				w.cond         = C_DIR_OOR;
				w.target       = ST_FAULT;
			end
			ST_LDPDE: begin
				w.ctl.ld_pde = 1'b1;
				w.cond       = C_RD_ABSENT;
				w.target     = ST_FAULT;
			end
			ST_PSCHK: begin
				w.cond   = C_PDE_SMALL;
				w.target = ST_RDTBL;
			end
			ST_BIGRW: begin
				w.cond   = C_PDE_DENY;
				w.target = ST_FAULT;
			end
			ST_BIGWB: begin
				w.ctl.mem_we    = 1'b1;
				w.ctl.addr_sel  = AS_DIR;
				w.ctl.wdata_sel = WS_PDE_BIG;
				w.ctl.res_sel   = RS_BIG;
				w.cond          = C_ALWAYS;
				w.target        = ST_DONE;
			end
			ST_RDTBL: begin
				w.ctl.mem_rd   = 1'b1;
				w.ctl.addr_sel = AS_TBL;
				w.cond         = C_TBL_OOR;
				w.target       = ST_FAULT;
			end
			ST_LDPTE: begin
				w.ctl.ld_pte = 1'b1;
				w.cond       = C_RD_ABSENT;
				w.target     = ST_FAULT;
			end
			ST_PTERW: begin
				w.cond   = C_PTE_DENY;
				w.target = ST_FAULT;
			end
			ST_WBPDE: begin
				w.ctl.mem_we    = 1'b1;
				w.ctl.addr_sel  = AS_DIR;
				w.ctl.wdata_sel = WS_PDE_ACC;
			end
			ST_WBPTE: begin
				w.ctl.mem_we    = 1'b1;
				w.ctl.addr_sel  = AS_TBL;
				w.ctl.wdata_sel = WS_PTE;
				w.ctl.res_sel   = RS_SMALL;
				w.cond          = C_ALWAYS;
				w.target        = ST_DONE;
			end
			ST_FAULT: begin
				w.ctl.res_sel   = RS_ONES;
				w.ctl.set_fault = 1'b1;
				w.cond          = C_ALWAYS;
				w.target        = ST_DONE;
			end
			ST_PASS: begin
				w.ctl.res_sel = RS_VA;
				w.cond        = C_ALWAYS;
				w.target      = ST_DONE;
			end
			ST_MEMDISP: begin
				w.cond   = C_NOT_READ;
				w.target = ST_WRCHK;
			end
			ST_RDMEM: begin
				w.ctl.mem_rd   = 1'b1;
				w.ctl.addr_sel = AS_ITEM;
				w.cond         = C_ITEM_OOR;
				w.target       = ST_RDOOR;
			end
			ST_RDLD: begin
				w.ctl.res_sel = RS_RDATA;
				w.cond        = C_ALWAYS;
				w.target      = ST_DONE;
			end
			ST_RDOOR: begin
				w.ctl.res_sel = RS_ONES;
				w.cond        = C_ALWAYS;
				w.target      = ST_DONE;
			end
			ST_WRCHK: begin
				w.cond   = C_NO_WRITE;
				w.target = ST_ZERO;
			end
			ST_WRMEM: begin
				w.ctl.mem_we    = 1'b1;
				w.ctl.addr_sel  = AS_ITEM;
				w.ctl.wdata_sel = WS_ITEM;
			end
			ST_ZERO: begin
				w.ctl.res_sel = RS_ZERO;
				w.cond        = C_ALWAYS;
				w.target      = ST_DONE;
			end
			ST_DONE: begin
				w.ctl.out_load = 1'b1;
				w.cond         = C_OUT_FREE;
				w.target       = ST_FETCH;
				w.nt_hold      = 1'b1;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = ST_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- hw/rtl/ptw_ram.sv -----
// generic single-clock ram, one write port and one registered read port
module ptw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/ptw_seq.sv -----
// microcode sequencer: step counter, control rom and branch logic
module ptw_seq
	import ptw_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctl_t  ctl
);

	step_t step_q;
	step_t step_nxt;
	uc_t   uc;
	logic  taken;

	// control word of the current step
	always_comb begin
		uc  = ucode_rom(step_q);
		ctl = uc.ctl;
	end

	// branch condition select
	always_comb begin
		case (uc.cond)
			C_NEVER:      taken = 1'b0;
			C_ALWAYS:     taken = 1'b1;
			C_IN_BEAT:    taken = stat.in_beat;
			C_OUT_FREE:   taken = stat.out_free;
			C_FUNC_MEM:   taken = stat.func_mem;
			C_PAGING_OFF: taken = stat.paging_off;
			C_DIR_OOR:    taken = stat.dir_oor;
			C_RD_ABSENT:  taken = stat.rd_absent;
			C_PDE_SMALL:  taken = stat.pde_small;
			C_PDE_DENY:   taken = stat.pde_deny;
			C_TBL_OOR:    taken = stat.tbl_oor;
			C_PTE_DENY:   taken = stat.pte_deny;
			C_NOT_READ:   taken = stat.not_read;
			C_ITEM_OOR:   taken = stat.item_oor;
			C_NO_WRITE:   taken = stat.no_write;
			default:      taken = 1'b0;
		endcase
	end

	// next step: jump, hold or fall through
	always_comb begin
		if (taken) begin
			step_nxt = uc.target;
		end else if (uc.nt_hold) begin
			step_nxt = step_q;
		end else begin
			step_nxt = step_t'(STEP_W'(step_q) + STEP_W'(1));
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_FETCH;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

// ----- hw/rtl/ptw_dp.sv -----
// walker datapath: config, item and entry registers, address and result muxes
module ptw_dp
	import ptw_pkg::*;
#(
	parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ctl_t                         ctl,
	output stat_t                        stat,
	// config writes
	input  logic                         cfg_valid,
	input  logic                         cfg_index,
	input  logic [31:0]                  cfg_data,
	// input beat
	input  logic                         s_tvalid,
	input  logic [63:0]                  s_tdata,
	input  logic [2:0]                   s_tuser,
	// output beat
	input  logic                         m_tready,
	output logic                         m_tvalid,
	output logic [63:0]                  m_tdata,
	output logic                         m_tuser,
	// table memory port
	output logic                         mem_we,
	output logic                         mem_re,
	output logic [$clog2(MEM_WORDS)-1:0] mem_addr,
	output logic [31:0]                  mem_wdata,
	input  logic [31:0]                  mem_rdata
);

	localparam int AW = $clog2(MEM_WORDS);

	logic [31:0] pdb_q;
	logic        pg_en_q;
	logic [1:0]  func_q;
	logic [31:0] va_q;
	logic        wr_q;
	logic [31:0] wdata_q;
	logic [31:0] pde_q;
	logic [31:0] pte_q;
	logic [31:0] res_q;
	logic        flt_q;
	logic [31:0] fault_addr_q;
	logic        out_valid_q;
	logic [31:0] out_res_q;
	logic        out_flt_q;
	logic [31:0] out_fa_q;

	logic [WORD_W-1:0] dir_word;
	logic [WORD_W-1:0] tbl_word;
	logic [WORD_W-1:0] item_word;
	logic [WORD_W-1:0] sel_word;
	logic              item_oor;
	logic              out_free;
	logic [31:0]       dirty_bit;
	logic [31:0]       acc_bit;
	logic [31:0]       res_nxt;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pdb_q   <= '0;
			pg_en_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PDB:    pdb_q   <= cfg_data;
				CFG_PAGING: pg_en_q <= cfg_data[0];
				default:    pdb_q   <= pdb_q;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (ctl.in_take && s_tvalid) begin
			va_q    <= s_tdata[31:0];
			wdata_q <= s_tdata[63:32];
			func_q  <= s_tuser[1:0];
			wr_q    <= s_tuser[2];
		end
	end

	// entry registers loaded from the read port
	always_ff @(posedge clk) begin
		if (ctl.ld_pde) begin
			pde_q <= mem_rdata;
		end
		if (ctl.ld_pte) begin
			pte_q <= mem_rdata;
		end
	end

	// word indexes of directory entry, table entry and direct item
	assign dir_word  = {pdb_q[31:12], va_q[31:22]};
	assign tbl_word  = {pde_q[31:12], va_q[21:12]};
	assign item_word = va_q[31:2];
	assign item_oor  = {2'b00, item_word} >= 32'(MEM_WORDS);

	// memory address select
	always_comb begin
		case (ctl.addr_sel)
			AS_DIR:  sel_word = dir_word;
			AS_TBL:  sel_word = tbl_word;
			AS_ITEM: sel_word = item_word;
			default: sel_word = item_word;
		endcase
	end

	assign mem_addr = sel_word[AW-1:0];
	assign mem_we   = ctl.mem_we;
	assign mem_re   = ctl.mem_rd;

	// accessed and dirty bit updates
	always_comb begin
		acc_bit          = '0;
		acc_bit[ENT_A]   = 1'b1;
		dirty_bit        = '0;
		dirty_bit[ENT_D] = wr_q;
	end

	// write data select
	always_comb begin
		case (ctl.wdata_sel)
			WS_ITEM:    mem_wdata = wdata_q;
			WS_PDE_ACC: mem_wdata = pde_q | acc_bit;
			WS_PDE_BIG: mem_wdata = pde_q | acc_bit | dirty_bit;
			WS_PTE:     mem_wdata = pte_q | acc_bit | dirty_bit;
			default:    mem_wdata = wdata_q;
		endcase
	end

	// result select
	always_comb begin
		case (ctl.res_sel)
			RS_VA:    res_nxt = va_q;
			RS_BIG:   res_nxt = {pde_q[31:22], va_q[21:0]};
			RS_SMALL: res_nxt = {pte_q[31:12], va_q[11:0]};
			RS_RDATA: res_nxt = mem_rdata;
			RS_ONES:  res_nxt = '1;
			RS_ZERO:  res_nxt = '0;
			default:  res_nxt = res_q;
		endcase
	end

	// result and fault flag of the item in work
	always_ff @(posedge clk) begin
		if (ctl.res_sel != RS_NONE) begin
			res_q <= res_nxt;
			flt_q <= ctl.set_fault;
		end
	end

	// latched faulting address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_addr_q <= '0;
		end else if (ctl.set_fault) begin
			fault_addr_q <= va_q;
		end
	end

	// output register
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load && out_free) begin
			out_res_q <= res_q;
			out_flt_q <= flt_q;
			out_fa_q  <= fault_addr_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_fa_q, out_res_q};
	assign m_tuser  = out_flt_q;

	// branch flags
	always_comb begin
		stat.in_beat    = s_tvalid;
		stat.out_free   = out_free;
		stat.func_mem   = func_q != FUNC_XLATE;
		stat.paging_off = !pg_en_q;
		stat.dir_oor    = {2'b00, dir_word} >= 32'(MEM_WORDS);
		stat.rd_absent  = !mem_rdata[ENT_P];
		stat.pde_small  = !pde_q[ENT_PS];
		stat.pde_deny   = wr_q && !pde_q[ENT_RW];
		stat.tbl_oor    = {2'b00, tbl_word} >= 32'(MEM_WORDS);
		stat.pte_deny   = wr_q && !pte_q[ENT_RW];
		stat.not_read   = func_q != FUNC_READ;
		stat.item_oor   = item_oor;
		stat.no_write   = (func_q != FUNC_WRITE) || item_oor;
	end

endmodule

// ----- hw/rtl/x86_two_level_page_walker.sv -----
// top level of the 32-bit two-level page table walker
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid / s_tready  tdata: address, write_data; tuser: func, write_access
// m_*      out  m_tvalid / m_tready  tdata: result_word, fault_address; tuser: fault
// cfg_*    in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item at a time, single table memory port; one microcode step per cycle,
// save that fetch holds until an input beat and done until the output register is free
// a finished result waits in the output register while the next item is taken
// reset clears control, the directory base and the fault address and enables paging;
// table memory is not cleared and has no sweep
module x86_two_level_page_walker
	import ptw_pkg::*;
#(
	parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] address, [63:32] write_data
	input  logic [2:0]  s_tuser,  // [1:0] func, [2] write_access
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // [31:0] result_word, [63:32] fault_address
	output logic        m_tuser   // [0] fault
);

	localparam int AW = $clog2(MEM_WORDS);

	ctl_t          ctl;
	stat_t         stat;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_addr;
	logic [31:0]   mem_wdata;
	logic [31:0]   mem_rdata;

	// config channel always ready; writes belong between items
	assign cfg_ready = 1'b1;
	assign s_tready  = ctl.in_take;

	ptw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	ptw_dp #(
		.MEM_WORDS (MEM_WORDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	// page table and data memory
	ptw_ram #(
		.WIDTH (32),
		.DEPTH (MEM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_addr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_addr),
		.rdata (mem_rdata)
	);

endmodule

// ----- hw/rtl/ptw_chk.sv -----
// port-level checker of the page walker and its bind
module ptw_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser
);

	logic [31:0] last_fa_q;

	// fault address seen on the last delivered beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_fa_q <= '0;
		end else if (m_tvalid && m_tready) begin
			last_fa_q <= m_tdata[63:32];
		end
	end

	// a faulting beat carries all ones
	a_fault_ones: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[31:0] == 32'hFFFF_FFFF)
		else $error("fault beat without all-ones result");

	// the latched fault address only moves on a fault
	a_fa_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tuser |-> m_tdata[63:32] == last_fa_q)
		else $error("fault address changed without a fault");

	// one item in work: no second beat taken right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on two back-to-back cycles");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result beat changed");

endmodule

bind x86_two_level_page_walker ptw_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
